// ===== hdl/boe_pkg.sv =====
// ----------------------------------------------------------------------------
// boe_pkg: shared types and constants for the binary outline extractor
// Frame limits, field widths, register indexes, queue entry and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package boe_pkg;

	// Frame limits
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	// Counter and line store address widths
	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	// Widths that hold a frame size itself
	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

	// Port field widths
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_COL_W = 11;
	localparam int OUT_ROW_W = 11;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Register reset values
	localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

	// Result queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Effective frame size, already clamped
	typedef struct packed {
		logic [WDIM_W-1:0] width;
		logic [HDIM_W-1:0] height;
	} boe_geom_t;

	// One classified pixel: up to two results
	typedef struct packed {
		logic                 has_upper;
		logic                 upper_outline;
		logic                 has_own;
		logic                 own_outline;
		logic                 frame_end;
		logic [OUT_COL_W-1:0] column;
		logic [OUT_ROW_W-1:0] row;
	} boe_entry_t;

	// Queue occupancy seen by front and back
	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] free;
	} boe_qstat_t;

	// Clamp a width register: zero acts as one, large values saturate
	function automatic logic [WDIM_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return WDIM_W'(1);
		end else if (32'(v) > MAX_WIDTH) begin
			return WDIM_W'(MAX_WIDTH);
		end else begin
			return WDIM_W'(v);
		end
	endfunction

	// Clamp a height register the same way
	function automatic logic [HDIM_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return HDIM_W'(1);
		end else if (32'(v) > MAX_HEIGHT) begin
			return HDIM_W'(MAX_HEIGHT);
		end else begin
			return HDIM_W'(v);
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/boe_pixel_if.sv =====
// ----------------------------------------------------------------------------
// boe_pixel_if: pixel input channel
// One binary pixel per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface boe_pixel_if;
	logic valid;
	logic ready;
	logic pixel_set;

	modport source (output valid, output pixel_set, input ready);
	modport sink (input valid, input pixel_set, output ready);
endinterface

`default_nettype wire

// ===== hdl/boe_result_if.sv =====
// ----------------------------------------------------------------------------
// boe_result_if: outline result channel
// One classified pixel with its position per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface boe_result_if;
	logic                          valid;
	logic                          ready;
	logic                          outline;
	logic [boe_pkg::OUT_COL_W-1:0] out_column;
	logic [boe_pkg::OUT_ROW_W-1:0] out_row;
	logic                          frame_end;

	modport source (output valid, output outline, output out_column, output out_row,
		output frame_end, input ready);
	modport sink (input valid, input outline, input out_column, input out_row,
		input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/boe_cfg_if.sv =====
// ----------------------------------------------------------------------------
// boe_cfg_if: configuration write channel
// Register index and write data per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface boe_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [boe_pkg::CFG_IDX_W-1:0] index;
	logic [boe_pkg::CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/boe_line_ram.sv =====
// ----------------------------------------------------------------------------
// boe_line_ram: one line store bank
// One bit per column, one write port and two registered read ports.
// Reads return the data held before a same-cycle write.
// ----------------------------------------------------------------------------
`default_nettype none

module boe_line_ram (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [boe_pkg::COL_W-1:0] addr_a,
	input  wire logic [boe_pkg::COL_W-1:0] addr_b,
	input  wire logic                     wr_en,
	input  wire logic [boe_pkg::COL_W-1:0] wr_addr,
	input  wire logic                     wr_data,
	output logic                          rd_a,
	output logic                          rd_b
);

	logic mem [boe_pkg::MAX_WIDTH];

	// Write the incoming pixel, read two columns
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a <= mem[addr_a];
			rd_b <= mem[addr_b];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/boe_front.sv =====
// ----------------------------------------------------------------------------
// boe_front: pixel intake and classification
// Tracks the pixel position, reads and updates the two line banks and
// classifies each pixel into a queue entry in the cycle after its beat.
// ----------------------------------------------------------------------------
`default_nettype none

module boe_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire boe_pkg::boe_geom_t  geom,
	input  wire boe_pkg::boe_qstat_t q_stat,
	boe_pixel_if.sink                pixel,
	output logic                     push,
	output boe_pkg::boe_entry_t      push_entry
);

	logic [boe_pkg::COL_W-1:0] col_q;
	logic [boe_pkg::ROW_W-1:0] row_q;
	logic                      bank_q;
	logic [boe_pkg::COL_W-1:0] x;
	logic [boe_pkg::ROW_W-1:0] r;
	logic                      last_col;
	logic                      last_row;
	logic                      accept;

	logic                      s1_valid_q;
	logic [boe_pkg::COL_W-1:0] x_s1;
	logic [boe_pkg::ROW_W-1:0] r_s1;
	logic                      pix_s1;
	logic                      bank_s1;
	logic                      last_col_s1;
	logic                      last_row_s1;
	logic                      prev_c_q;

	logic rd0_a, rd0_b, rd1_a, rd1_b;
	logic mid_c, mid_r, up_v;
	logic up_n, lf_n, rt_n;
	logic has_upper;

	// Wrap a position that lies past the current frame size
	assign x = (boe_pkg::WDIM_W'(col_q) >= geom.width) ? '0 : col_q;
	assign r = (boe_pkg::HDIM_W'(row_q) >= geom.height) ? '0 : row_q;
	assign last_col = (boe_pkg::WDIM_W'(x) == geom.width - boe_pkg::WDIM_W'(1));
	assign last_row = (boe_pkg::HDIM_W'(r) == geom.height - boe_pkg::HDIM_W'(1));

	// Take a beat only while the queue has room for it and the one in flight
	assign pixel.ready = (q_stat.free > boe_pkg::QCNT_W'(s1_valid_q));
	assign accept = pixel.valid & pixel.ready;

	// Advance the position counters and flip banks at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (last_col) begin
				col_q  <= '0;
				bank_q <= ~bank_q;
				row_q  <= last_row ? '0 : r + boe_pkg::ROW_W'(1);
			end else begin
				col_q <= x + boe_pkg::COL_W'(1);
			end
		end
	end

	// Bank selected by bank_q holds the row two above and takes the new pixel
	boe_line_ram u_bank0 (
		.clk     (clk),
		.rd_en   (accept),
		.addr_a  (x),
		.addr_b  (x + boe_pkg::COL_W'(1)),
		.wr_en   (accept & ~bank_q),
		.wr_addr (x),
		.wr_data (pixel.pixel_set),
		.rd_a    (rd0_a),
		.rd_b    (rd0_b)
	);

	boe_line_ram u_bank1 (
		.clk     (clk),
		.rd_en   (accept),
		.addr_a  (x),
		.addr_b  (x + boe_pkg::COL_W'(1)),
		.wr_en   (accept & bank_q),
		.wr_addr (x),
		.wr_data (pixel.pixel_set),
		.rd_a    (rd1_a),
		.rd_b    (rd1_b)
	);

	// Hold the accepted pixel while the line data comes back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1        <= x;
			r_s1        <= r;
			pix_s1      <= pixel.pixel_set;
			bank_s1     <= bank_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
		// Keep the center of the row above as the next pixel's left neighbor
		if (s1_valid_q) begin
			prev_c_q <= mid_c;
		end
	end

	// Pick row above and row two above from the banks
	assign mid_c = bank_s1 ? rd0_a : rd1_a;
	assign mid_r = bank_s1 ? rd0_b : rd1_b;
	assign up_v  = bank_s1 ? rd1_a : rd0_a;

	// Neighbors of the pixel above; outside the frame reads blank
	assign up_n = (r_s1 > boe_pkg::ROW_W'(1)) & up_v;
	assign lf_n = (x_s1 != '0) & prev_c_q;
	assign rt_n = ~last_col_s1 & mid_r;
	assign has_upper = (r_s1 != '0);

	// Build the queue entry
	always_comb begin
		push_entry.has_upper     = has_upper;
		push_entry.upper_outline = mid_c & (~up_n | ~lf_n | ~rt_n | ~pix_s1);
		push_entry.has_own       = last_row_s1;
		push_entry.own_outline   = pix_s1;
		push_entry.frame_end     = last_row_s1 & last_col_s1;
		push_entry.column        = boe_pkg::OUT_COL_W'(x_s1);
		push_entry.row           = boe_pkg::OUT_ROW_W'(r_s1);
	end

	// Drop pixels of the first row that give no result
	assign push = s1_valid_q & (has_upper | last_row_s1);

endmodule

`default_nettype wire

// ===== hdl/boe_queue.sv =====
// ----------------------------------------------------------------------------
// boe_queue: short queue of classified pixels
// Decouples classification from result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module boe_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire boe_pkg::boe_entry_t push_entry,
	input  wire logic                pop,
	output boe_pkg::boe_entry_t      head,
	output boe_pkg::boe_qstat_t      q_stat
);

	boe_pkg::boe_entry_t         slots [boe_pkg::QUEUE_DEPTH];
	logic [boe_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [boe_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [boe_pkg::QCNT_W-1:0] count_q;

	function automatic logic [boe_pkg::QPTR_W-1:0] next_ptr(
		input logic [boe_pkg::QPTR_W-1:0] p);
		if (p == boe_pkg::QPTR_W'(boe_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end else begin
			return p + boe_pkg::QPTR_W'(1);
		end
	endfunction

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + boe_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - boe_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = slots[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.free  = boe_pkg::QCNT_W'(boe_pkg::QUEUE_DEPTH) - count_q;

endmodule

`default_nettype wire

// ===== hdl/boe_back.sv =====
// ----------------------------------------------------------------------------
// boe_back: result delivery
// Splits each queue entry into one or two result beats through an output
// register; on the last row the upper result goes first.
// ----------------------------------------------------------------------------
`default_nettype none

module boe_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire boe_pkg::boe_entry_t head,
	input  wire boe_pkg::boe_qstat_t q_stat,
	output logic                     pop,
	boe_result_if.source             result
);

	logic                          out_valid_q;
	logic                          outline_q;
	logic [boe_pkg::OUT_COL_W-1:0] column_q;
	logic [boe_pkg::OUT_ROW_W-1:0] row_q;
	logic                          frame_end_q;
	logic                          phase_q;
	logic                          load;
	logic                          take_upper;

	// Load a new beat when the output register is free or drains now
	assign load       = ~q_stat.empty & (~out_valid_q | result.ready);
	assign take_upper = head.has_upper & ~phase_q;
	// Keep the entry for its second beat when it has two results
	assign pop        = load & ~(take_upper & head.has_own);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= take_upper & head.has_own;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Fill the output payload
	always_ff @(posedge clk) begin
		if (load) begin
			column_q <= head.column;
			if (take_upper) begin
				outline_q   <= head.upper_outline;
				row_q       <= head.row - boe_pkg::OUT_ROW_W'(1);
				frame_end_q <= 1'b0;
			end else begin
				outline_q   <= head.own_outline;
				row_q       <= head.row;
				frame_end_q <= head.frame_end;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.outline    = outline_q;
	assign result.out_column = column_q;
	assign result.out_row    = row_q;
	assign result.frame_end  = frame_end_q;

endmodule

`default_nettype wire

// ===== hdl/binary_outline_extractor_unit.sv =====
// Path: a result beat comes from the pixel below through the classification
//   register, the queue and the output register. Throughput: one pixel per
//   cycle while results are taken; the last row's two results per pixel slow it.
// Reset: clears position counters, bank select, queue and output valid; the
//   width and height registers return to 640 and 480; line stores keep contents.
// ----------------------------------------------------------------------------
// binary_outline_extractor_unit: 4-neighbor inner boundary of a binary stream
// Front reads two line banks and classifies pixels, a short queue parts it
// from the back, which delivers one result beat per cycle while results are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_outline_extractor_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	boe_cfg_if.sink      cfg,
	boe_pixel_if.sink    pixel,
	boe_result_if.source result
);

	logic [boe_pkg::WDIM_W-1:0] width_q;
	logic [boe_pkg::HDIM_W-1:0] height_q;
	boe_pkg::boe_geom_t         geom;
	boe_pkg::boe_qstat_t        q_stat;
	boe_pkg::boe_entry_t        push_entry;
	boe_pkg::boe_entry_t        head;
	logic                       push;
	logic                       pop;

	// Store clamped frame size on each register write
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= boe_pkg::clamp_width(boe_pkg::RESET_WIDTH);
			height_q <= boe_pkg::clamp_height(boe_pkg::RESET_HEIGHT);
		end else if (cfg.valid) begin
			case (cfg.index)
				boe_pkg::REG_IMAGE_WIDTH:  width_q  <= boe_pkg::clamp_width(cfg.data);
				boe_pkg::REG_IMAGE_HEIGHT: height_q <= boe_pkg::clamp_height(cfg.data);
				default: ;
			endcase
		end
	end

	assign geom.width  = width_q;
	assign geom.height = height_q;

	boe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.q_stat     (q_stat),
		.pixel      (pixel),
		.push       (push),
		.push_entry (push_entry)
	);

	boe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	boe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.result (result)
	);

	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_stat.free != '0))
		else $error("queue push while full");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue pop while empty");

	// An accepted pixel always finds room once it is classified
	a_room_for_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> (q_stat.free != '0) || !push)
		else $error("classified pixel has no queue slot");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for binary_outline_extractor_unit
// Streams binary frames through the pixel channel under random gaps and
// result stalls, predicts every outline beat from its own model of the two
// line banks and position counters, and compares each result beat field by
// field. Covers reset sizes, tiny and saturated frames, resizing mid-frame,
// a long result stall and a random stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PIXELS = 200;
	localparam int EXTREME_PIXELS = 40;
	localparam logic [boe_pkg::CFG_W-1:0] DEFAULT_WIDTH  = 12'd640;
	localparam logic [boe_pkg::CFG_W-1:0] DEFAULT_HEIGHT = 12'd480;

	typedef struct {
		bit                          outline;
		bit [boe_pkg::OUT_COL_W-1:0] column;
		bit [boe_pkg::OUT_ROW_W-1:0] row;
		bit                          frame_end;
	} outline_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	boe_cfg_if    cfg_ch ();
	boe_pixel_if  pix_ch ();
	boe_result_if res_ch ();

	binary_outline_extractor_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pixel  (pix_ch),
		.result (res_ch)
	);

	// Model state: two line banks, bank select, position and sizes
	bit                          line_mem [2][boe_pkg::MAX_WIDTH];
	bit                          bank_sel = 1'b0;
	int unsigned                 col_pos = 0;
	int unsigned                 row_pos = 0;
	logic [boe_pkg::CFG_W-1:0]   width_reg = DEFAULT_WIDTH;
	logic [boe_pkg::CFG_W-1:0]   height_reg = DEFAULT_HEIGHT;

	outline_beat_t      pending_outlines [$];
	int unsigned        mismatch_count = 0;
	int unsigned        cycle_count = 0;

	// Sender pacing and receiver stall pattern
	int unsigned        burst_left = 0;
	bit                 pacing_on = 1'b1;
	logic [15:0]        rx_pattern = 16'hB6DB;
	logic [3:0]         rx_phase = '0;
	int unsigned        hold_requests = 0;
	int unsigned        holds_granted = 0;
	int unsigned        hold_left = 0;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int unsigned clamped_size(logic [boe_pkg::CFG_W-1:0] v,
		int unsigned limit);
		if (v == '0) return 1;
		if (v > limit) return limit;
		return 32'(v);
	endfunction

	// Advance the model by one pixel and queue the beats it releases
	function automatic void classify_pixel(bit pix);
		int unsigned   w, h, x, r;
		bit            up_bank, mid_bank, center, above, left_nb, right_nb;
		outline_beat_t beat;
		w = clamped_size(width_reg, boe_pkg::MAX_WIDTH);
		h = clamped_size(height_reg, boe_pkg::MAX_HEIGHT);
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		x = col_pos;
		r = row_pos;
		up_bank = bank_sel;
		mid_bank = !bank_sel;
		// the pixel above is now complete: all four neighbors are known
		if (r >= 1) begin
			center   = line_mem[mid_bank][x];
			above    = (r >= 2) ? line_mem[up_bank][x] : 1'b0;
			left_nb  = (x > 0) ? line_mem[mid_bank][x - 1] : 1'b0;
			right_nb = (x != w - 1) ? line_mem[mid_bank][x + 1] : 1'b0;
			beat.outline   = center && (!above || !left_nb || !right_nb || !pix);
			beat.column    = boe_pkg::OUT_COL_W'(x);
			beat.row       = boe_pkg::OUT_ROW_W'(r - 1);
			beat.frame_end = 1'b0;
			pending_outlines.push_back(beat);
		end
		// below the last row lies the outside
		if (r == h - 1) begin
			beat.outline   = pix;
			beat.column    = boe_pkg::OUT_COL_W'(x);
			beat.row       = boe_pkg::OUT_ROW_W'(r);
			beat.frame_end = (x == w - 1);
			pending_outlines.push_back(beat);
		end
		line_mem[up_bank][x] = pix;
		if (x == w - 1) begin
			col_pos = 0;
			bank_sel = !bank_sel;
			row_pos = (r == h - 1) ? 0 : r + 1;
		end else begin
			col_pos = x + 1;
		end
	endfunction

	function automatic void check_outline(logic ol, logic [boe_pkg::OUT_COL_W-1:0] col,
		logic [boe_pkg::OUT_ROW_W-1:0] row, logic fe);
		outline_beat_t want;
		if (pending_outlines.size() == 0) begin
			$error("unexpected result beat: column %0d row %0d", col, row);
			mismatch_count++;
			return;
		end
		want = pending_outlines.pop_front();
		if (ol !== want.outline) begin
			$error("outline: expected %0d, got %0d", want.outline, ol);
			mismatch_count++;
		end
		if (col !== want.column) begin
			$error("out_column: expected %0d, got %0d", want.column, col);
			mismatch_count++;
		end
		if (row !== want.row) begin
			$error("out_row: expected %0d, got %0d", want.row, row);
			mismatch_count++;
		end
		if (fe !== want.frame_end) begin
			$error("frame_end: expected %0d, got %0d", want.frame_end, fe);
			mismatch_count++;
		end
	endfunction

	// Watch every channel: register writes, pixels in, results out
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					boe_pkg::REG_IMAGE_WIDTH: width_reg = cfg_ch.data;
					boe_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_ch.data;
					default: ;
				endcase
			end
			if (pix_ch.valid && pix_ch.ready) classify_pixel(pix_ch.pixel_set);
			if (res_ch.valid && res_ch.ready) begin
				check_outline(res_ch.outline, res_ch.out_column, res_ch.out_row,
					res_ch.frame_end);
			end
		end
	end

	// Result receiver: long hold-offs on request, else a rotating stall pattern
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_requests != holds_granted) begin
			holds_granted <= holds_granted + 1;
			hold_left <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= rx_pattern[rx_phase];
		end
		rx_phase <= rx_phase + 4'd1;
	end

	function automatic bit random_pixel(int unsigned density);
		return $urandom_range(0, 99) < density;
	endfunction

	// Offer one pixel beat; open a new burst with an optional gap first
	task automatic offer_pixel(bit pix);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (pacing_on && $urandom_range(0, 2) != 0) begin
				pix_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		burst_left--;
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_set <= pix;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted beat has come out
	task automatic drain_results();
		pix_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_outlines.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [boe_pkg::CFG_IDX_W-1:0] idx,
		logic [boe_pkg::CFG_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_size(logic [boe_pkg::CFG_W-1:0] w, logic [boe_pkg::CFG_W-1:0] h);
		drain_results();
		write_register(boe_pkg::REG_IMAGE_WIDTH, w);
		write_register(boe_pkg::REG_IMAGE_HEIGHT, h);
	endtask

	// Send random pixels up to the end of the current frame
	task automatic finish_frame();
		int unsigned w, h, c, r, left;
		w = clamped_size(width_reg, boe_pkg::MAX_WIDTH);
		h = clamped_size(height_reg, boe_pkg::MAX_HEIGHT);
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;
		left = (c == 0 && r == 0) ? 0 : (h - r) * w - c;
		repeat (left) offer_pixel(random_pixel(50));
	endtask

	// Reset sizes: one full 640-pixel row, then the head of the next row
	task automatic test_reset_sizes();
		repeat (DEFAULT_WIDTH + 2) offer_pixel(random_pixel(60));
	endtask

	// Zero sizes, single column, single row and a solid block
	task automatic test_small_frames();
		bit column_px [4] = '{1'b1, 1'b1, 1'b0, 1'b1};
		bit row_px [5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
		set_size('0, '0);
		offer_pixel(1'b0);
		offer_pixel(1'b1);
		set_size(12'd1, 12'd4);
		foreach (column_px[i]) offer_pixel(column_px[i]);
		set_size(12'd5, 12'd1);
		foreach (row_px[i]) offer_pixel(row_px[i]);
		// only the center of a solid 3x3 block is interior
		set_size(12'd3, 12'd3);
		repeat (9) offer_pixel(1'b1);
	endtask

	// Saturated and maximum sizes, a short run of pixels on each
	task automatic test_extreme_sizes();
		set_size(12'hFFF, 12'd1);
		repeat (EXTREME_PIXELS) offer_pixel(random_pixel(70));
		set_size(12'd1, 12'd2049);
		repeat (EXTREME_PIXELS) offer_pixel(random_pixel(70));
		set_size(12'd2048, 12'd1);
		repeat (EXTREME_PIXELS) offer_pixel(random_pixel(50));
	endtask

	// Shrink width and height while counters sit past the new size
	task automatic test_mid_frame_resize();
		set_size(12'd40, 12'd6);
		repeat (110) offer_pixel(random_pixel(75));
		drain_results();
		write_register(boe_pkg::REG_IMAGE_WIDTH, 12'd10);
		repeat (15) offer_pixel(random_pixel(75));
		drain_results();
		write_register(boe_pkg::REG_IMAGE_HEIGHT, 12'd2);
		finish_frame();
	endtask

	// Hold the receiver off while pixels keep coming, then release it
	task automatic test_backpressure();
		set_size(12'd8, 12'd6);
		pacing_on = 1'b0;
		rx_pattern = 16'hFFFF;
		hold_requests++;
		repeat (144) offer_pixel(random_pixel(80));
		pacing_on = 1'b1;
		rx_pattern = 16'hB6DB;
	endtask

	function automatic logic [boe_pkg::CFG_W-1:0] random_size();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return boe_pkg::CFG_W'($urandom_range(2049, 4095));
			2: return boe_pkg::CFG_W'($urandom_range(1, 2048));
			default: return boe_pkg::CFG_W'($urandom_range(1, 16));
		endcase
	endfunction

	// Widths stay inside the columns that earlier tests wrote in both banks
	function automatic logic [boe_pkg::CFG_W-1:0] random_width();
		case ($urandom_range(0, 19))
			0: return '0;
			default: return boe_pkg::CFG_W'($urandom_range(1, 16));
		endcase
	endfunction

	// Phases of random pixels; sizes may change between or inside frames
	task automatic test_random_stream();
		int unsigned sent, len, density;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			drain_results();
			case ($urandom_range(0, 3))
				0: write_register(boe_pkg::REG_IMAGE_WIDTH, random_width());
				1: write_register(boe_pkg::REG_IMAGE_HEIGHT, random_size());
				2: begin
					write_register(boe_pkg::REG_IMAGE_WIDTH, random_width());
					write_register(boe_pkg::REG_IMAGE_HEIGHT, random_size());
				end
				default: ;
			endcase
			pacing_on = ($urandom_range(0, 3) != 0);
			rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1111);
			case ($urandom_range(0, 2))
				0: density = 15;
				1: density = 50;
				default: density = 85;
			endcase
			len = $urandom_range(20, 120);
			repeat (len) offer_pixel(random_pixel(density));
			sent += len;
		end
	endtask

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.pixel_set = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_sizes();
		test_small_frames();
		test_extreme_sizes();
		test_mid_frame_resize();
		test_backpressure();
		test_random_stream();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
